[rtl/det_pkg.sv]
package det_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int STEP_WIDTH = 8;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_DEBOUNCE = 3'd1,
		ST_EXECUTE = 3'd2,
		ST_COOLDOWN = 3'd3,
		ST_BLOCKED = 3'd4
	} state_t;

	typedef enum logic [1:0] {
		ACT_RUN = 2'd0,
		ACT_RESET = 2'd1,
		ACT_READ = 2'd2,
		ACT_BLOCK = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_COOLDOWN = 2'd1,
		REG_HAS_DEP = 2'd2,
		REG_NONE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		action_t action;
		logic condition_met;
		logic dependent_blocked;
		logic [STEP_WIDTH-1:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic [2:0] state_now;
		logic fired;
		logic release_dependent;
		logic event_flag;
	} out_item_t;

endpackage

[rtl/debounced_event_trigger.sv]
// Debounced event trigger: a five-state trigger (idle, debounce, execute, cooldown,
// blocked) with a saturating elapsed-tick timer of TIMER_WIDTH bits. Each item adds
// its time step to the timer and then performs its action; one result comes back per
// item. The whole state update is a single pass between the input register and the
// result register, so one item is taken per clock while result_ready stays high; a
// stalled result register holds the input register, and item_ready falls once both
// are full. Each item waits in the input register and its result is then registered in the
// result register, from which it is taken. Configuration writes are always accepted
// (cfg_ready is always high) and are meant for idle periods.
module debounced_event_trigger #(
	parameter int TIMER_WIDTH = det_pkg::TIMER_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input det_pkg::cfg_reg_t cfg_index,
	input logic [det_pkg::CFG_WIDTH-1:0] cfg_data,
	input logic item_valid,
	output logic item_ready,
	input det_pkg::in_item_t item,
	output logic result_valid,
	input logic result_ready,
	output det_pkg::out_item_t result
);

	logic valid_s1;
	det_pkg::in_item_t item_s1;
	logic load_ready;
	logic step;
	det_pkg::out_item_t result_s1;

	assign cfg_ready = 1'b1;
	assign item_ready = !valid_s1 || load_ready;
	assign step = valid_s1 && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	det_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(step),
		.item(item_s1),
		.result(result_s1)
	);

	det_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load_valid(valid_s1),
		.load_ready(load_ready),
		.load_data(result_s1),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

[rtl/det_core.sv]
module det_core #(
	parameter int TIMER_WIDTH = det_pkg::TIMER_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input det_pkg::cfg_reg_t cfg_index,
	input logic [det_pkg::CFG_WIDTH-1:0] cfg_data,
	input logic step,
	input det_pkg::in_item_t item,
	output det_pkg::out_item_t result
);

	localparam int CW = (TIMER_WIDTH > det_pkg::CFG_WIDTH) ? TIMER_WIDTH : det_pkg::CFG_WIDTH;

	logic [det_pkg::CFG_WIDTH-1:0] debounce_q;
	logic [det_pkg::CFG_WIDTH-1:0] cooldown_q;
	logic has_dep_q;

	det_pkg::state_t state_q, state_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic pending_q, pending_d;

	logic [TIMER_WIDTH:0] sum;
	logic [TIMER_WIDTH-1:0] timer_sat;
	logic gate;
	logic debounce_done;
	logic cooldown_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			cooldown_q <= '0;
			has_dep_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				det_pkg::REG_DEBOUNCE: debounce_q <= cfg_data;
				det_pkg::REG_COOLDOWN: cooldown_q <= cfg_data;
				det_pkg::REG_HAS_DEP: has_dep_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturating elapsed timer
	assign sum = {1'b0, timer_q} + (TIMER_WIDTH+1)'(item.time_step);
	assign timer_sat = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];

	assign gate = item.condition_met && (!has_dep_q || item.dependent_blocked);
	assign debounce_done = CW'(timer_sat) >= CW'(debounce_q);
	assign cooldown_done = CW'(timer_sat) >= CW'(cooldown_q);

	always_comb begin
		state_d = state_q;
		timer_d = timer_sat;
		pending_d = pending_q;
		unique case (item.action)
			det_pkg::ACT_RUN: begin
				unique case (state_q)
					det_pkg::ST_IDLE: begin
						if (gate) begin
							if (debounce_q != '0) begin
								timer_d = '0;
								state_d = det_pkg::ST_DEBOUNCE;
							end else begin
								state_d = det_pkg::ST_EXECUTE;
							end
						end
					end
					det_pkg::ST_DEBOUNCE: begin
						if (!gate) begin
							state_d = det_pkg::ST_IDLE;
						end else if (debounce_done) begin
							state_d = det_pkg::ST_EXECUTE;
						end
					end
					det_pkg::ST_EXECUTE: begin
						pending_d = 1'b1;
						timer_d = '0;
						state_d = det_pkg::ST_COOLDOWN;
					end
					det_pkg::ST_COOLDOWN: begin
						if (cooldown_done) begin
							state_d = has_dep_q ? det_pkg::ST_BLOCKED : det_pkg::ST_IDLE;
						end
					end
					default: ;
				endcase
			end
			det_pkg::ACT_RESET: state_d = det_pkg::ST_IDLE;
			det_pkg::ACT_READ: pending_d = 1'b0;
			det_pkg::ACT_BLOCK: begin
				if (state_q == det_pkg::ST_IDLE) begin
					state_d = det_pkg::ST_BLOCKED;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.state_now = state_d;
		result.fired = (item.action == det_pkg::ACT_RUN) && (state_q == det_pkg::ST_EXECUTE);
		result.release_dependent = (item.action == det_pkg::ACT_RUN) &&
			(state_q == det_pkg::ST_COOLDOWN) && cooldown_done && has_dep_q;
		result.event_flag = (item.action == det_pkg::ACT_READ) && pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= det_pkg::ST_IDLE;
			timer_q <= '0;
			pending_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			timer_q <= timer_d;
			pending_q <= pending_d;
		end
	end

endmodule

[rtl/det_out_reg.sv]
module det_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load_valid,
	output logic load_ready,
	input det_pkg::out_item_t load_data,
	output logic result_valid,
	input logic result_ready,
	output det_pkg::out_item_t result
);

	logic valid_q;
	det_pkg::out_item_t data_q;

	assign load_ready = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			data_q <= load_data;
		end
	end

	assign result_valid = valid_q;
	assign result = data_q;

endmodule

[rtl/det_checker.sv]
module det_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input det_pkg::out_item_t result
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// fired, release and read flag come from different cases
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $countones({result.fired, result.release_dependent,
			result.event_flag}) <= 1)
		else $error("conflicting result flags");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.fired |-> result.state_now == det_pkg::ST_COOLDOWN)
		else $error("fired without entering cooldown");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.release_dependent |->
			result.state_now == det_pkg::ST_BLOCKED)
		else $error("release without entering blocked");

endmodule

bind debounced_event_trigger det_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
